FILE: hw/rtl/av1sh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// av1sh_pkg
// Shared types, syntax step codes and the step control table of the
// sequence header parser.
// ----------------------------------------------------------------------------
package av1sh_pkg;

  localparam int StepW = 6;
  typedef logic [StepW-1:0] step_t;

  // syntax step codes
  localparam step_t S_PROFILE   = 6'd0;
  localparam step_t S_STILL     = 6'd1;
  localparam step_t S_REDUCED   = 6'd2;
  localparam step_t S_LEVEL_R   = 6'd3;
  localparam step_t S_TIMING    = 6'd4;
  localparam step_t S_NUM_UNITS = 6'd5;
  localparam step_t S_TIME_SCL  = 6'd6;
  localparam step_t S_EQUAL_PIC = 6'd7;
  localparam step_t S_UVLC_ZERO = 6'd8;
  localparam step_t S_UVLC_VAL  = 6'd9;
  localparam step_t S_DMI       = 6'd10;
  localparam step_t S_BUF_LEN   = 6'd11;
  localparam step_t S_DEC_TICK  = 6'd12;
  localparam step_t S_BRT_LEN   = 6'd13;
  localparam step_t S_FPT_LEN   = 6'd14;
  localparam step_t S_IDD       = 6'd15;
  localparam step_t S_OP_CNT    = 6'd16;
  localparam step_t S_OP_IDC    = 6'd17;
  localparam step_t S_OP_LEVEL  = 6'd18;
  localparam step_t S_OP_TIER   = 6'd19;
  localparam step_t S_OP_DM     = 6'd20;
  localparam step_t S_OP_DEC    = 6'd21;
  localparam step_t S_OP_ENC    = 6'd22;
  localparam step_t S_OP_LOW    = 6'd23;
  localparam step_t S_OP_IDD_P  = 6'd24;
  localparam step_t S_OP_IDD    = 6'd25;
  localparam step_t S_FWB       = 6'd26;
  localparam step_t S_FHB       = 6'd27;
  localparam step_t S_FW        = 6'd28;
  localparam step_t S_FH        = 6'd29;
  localparam step_t S_FID       = 6'd30;
  localparam step_t S_DFID      = 6'd31;
  localparam step_t S_AFID      = 6'd32;
  localparam step_t S_TOOLS3    = 6'd33;
  localparam step_t S_TOOLS4    = 6'd34;
  localparam step_t S_OH        = 6'd35;
  localparam step_t S_JNT       = 6'd36;
  localparam step_t S_CH_SCT    = 6'd37;
  localparam step_t S_FO_SCT    = 6'd38;
  localparam step_t S_CH_IMV    = 6'd39;
  localparam step_t S_FO_IMV    = 6'd40;
  localparam step_t S_OH_BITS   = 6'd41;
  localparam step_t S_TAIL3     = 6'd42;
  localparam step_t S_HBD       = 6'd43;
  localparam step_t S_TWELVE    = 6'd44;
  localparam step_t S_MONO      = 6'd45;
  localparam step_t S_CD        = 6'd46;
  localparam step_t S_CP        = 6'd47;
  localparam step_t S_TC        = 6'd48;
  localparam step_t S_MC        = 6'd49;
  localparam step_t S_RANGE     = 6'd50;
  localparam step_t S_SSX       = 6'd51;
  localparam step_t S_SSY       = 6'd52;
  localparam step_t S_CSP       = 6'd53;
  localparam step_t S_SEP_UV    = 6'd54;
  localparam step_t S_FILM      = 6'd55;

  // field length source
  localparam logic [2:0] LEN_CONST = 3'd0;
  localparam logic [2:0] LEN_ZC    = 3'd1;
  localparam logic [2:0] LEN_DLEN  = 3'd2;
  localparam logic [2:0] LEN_FW    = 3'd3;
  localparam logic [2:0] LEN_FH    = 3'd4;

  localparam logic [23:0] CDESC_UNSPEC = 24'h020202;
  localparam logic [23:0] CDESC_SRGB   = 24'h010D00;
  localparam logic [5:0]  UVLC_MAX     = 6'd32;

  typedef struct packed {
    logic [2:0] len_kind;
    logic [5:0] len_const;
    step_t      nxt;
  } step_ctl_t;

  // control word per syntax step: field length and default successor
  function automatic step_ctl_t step_ctl(input step_t s);
    step_ctl_t c;
    c.len_kind  = LEN_CONST;
    c.len_const = 6'd1;
    c.nxt       = S_FILM;
    unique case (s)
      S_PROFILE:   begin c.len_const = 6'd3;  c.nxt = S_STILL;      end
      S_STILL:     begin c.nxt = S_REDUCED;                         end
      S_REDUCED:   begin c.nxt = S_TIMING;                          end
      S_LEVEL_R:   begin c.len_const = 6'd5;  c.nxt = S_FWB;        end
      S_TIMING:    begin c.nxt = S_IDD;                             end
      S_NUM_UNITS: begin c.len_const = 6'd32; c.nxt = S_TIME_SCL;   end
      S_TIME_SCL:  begin c.len_const = 6'd32; c.nxt = S_EQUAL_PIC;  end
      S_EQUAL_PIC: begin c.nxt = S_DMI;                             end
      S_UVLC_ZERO: begin c.nxt = S_DMI;                             end
      S_UVLC_VAL:  begin c.len_kind = LEN_ZC; c.nxt = S_DMI;        end
      S_DMI:       begin c.nxt = S_IDD;                             end
      S_BUF_LEN:   begin c.len_const = 6'd5;  c.nxt = S_DEC_TICK;   end
      S_DEC_TICK:  begin c.len_const = 6'd32; c.nxt = S_BRT_LEN;    end
      S_BRT_LEN:   begin c.len_const = 6'd5;  c.nxt = S_FPT_LEN;    end
      S_FPT_LEN:   begin c.len_const = 6'd5;  c.nxt = S_IDD;        end
      S_IDD:       begin c.nxt = S_OP_CNT;                          end
      S_OP_CNT:    begin c.len_const = 6'd5;  c.nxt = S_OP_IDC;     end
      S_OP_IDC:    begin c.len_const = 6'd12; c.nxt = S_OP_LEVEL;   end
      S_OP_LEVEL:  begin c.len_const = 6'd5;  c.nxt = S_OP_TIER;    end
      S_OP_TIER:   begin c.nxt = S_OP_DM;                           end
      S_OP_DM:     begin c.nxt = S_OP_DEC;                          end
      S_OP_DEC:    begin c.len_kind = LEN_DLEN; c.nxt = S_OP_ENC;   end
      S_OP_ENC:    begin c.len_kind = LEN_DLEN; c.nxt = S_OP_LOW;   end
      S_OP_LOW:    begin c.nxt = S_OP_IDD_P;                        end
      S_OP_IDD_P:  begin c.nxt = S_OP_IDD;                          end
      S_OP_IDD:    begin c.len_const = 6'd4;  c.nxt = S_FWB;        end
      S_FWB:       begin c.len_const = 6'd4;  c.nxt = S_FHB;        end
      S_FHB:       begin c.len_const = 6'd4;  c.nxt = S_FW;         end
      S_FW:        begin c.len_kind = LEN_FW; c.nxt = S_FH;         end
      S_FH:        begin c.len_kind = LEN_FH; c.nxt = S_FID;        end
      S_FID:       begin c.nxt = S_TOOLS3;                          end
      S_DFID:      begin c.len_const = 6'd4;  c.nxt = S_AFID;       end
      S_AFID:      begin c.len_const = 6'd3;  c.nxt = S_TOOLS3;     end
      S_TOOLS3:    begin c.len_const = 6'd3;  c.nxt = S_TOOLS4;     end
      S_TOOLS4:    begin c.len_const = 6'd4;  c.nxt = S_OH;         end
      S_OH:        begin c.nxt = S_CH_SCT;                          end
      S_JNT:       begin c.len_const = 6'd2;  c.nxt = S_CH_SCT;     end
      S_CH_SCT:    begin c.nxt = S_FO_SCT;                          end
      S_FO_SCT:    begin c.nxt = S_TAIL3;                           end
      S_CH_IMV:    begin c.nxt = S_FO_IMV;                          end
      S_FO_IMV:    begin c.nxt = S_TAIL3;                           end
      S_OH_BITS:   begin c.len_const = 6'd3;  c.nxt = S_TAIL3;      end
      S_TAIL3:     begin c.len_const = 6'd3;  c.nxt = S_HBD;        end
      S_HBD:       begin c.nxt = S_MONO;                            end
      S_TWELVE:    begin c.nxt = S_MONO;                            end
      S_MONO:      begin c.nxt = S_CD;                              end
      S_CD:        begin c.nxt = S_CP;                              end
      S_CP:        begin c.len_const = 6'd8;  c.nxt = S_TC;         end
      S_TC:        begin c.len_const = 6'd8;  c.nxt = S_MC;         end
      S_MC:        begin c.len_const = 6'd8;  c.nxt = S_RANGE;      end
      S_RANGE:     begin c.nxt = S_SEP_UV;                          end
      S_SSX:       begin c.nxt = S_SSY;                             end
      S_SSY:       begin c.nxt = S_SEP_UV;                          end
      S_CSP:       begin c.len_const = 6'd2;  c.nxt = S_SEP_UV;     end
      S_SEP_UV:    begin c.nxt = S_FILM;                            end
      default:     begin c.nxt = S_FILM;                            end
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/av1_sequence_header_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// av1_sequence_header_parser_core
// Bit-serial sequence header parser: a step table drives a field shifter,
// one syntax bit per cycle while a byte is being shifted, and one result beat is given per header.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid/in_ready   | payload_byte, is_last
//  out_    | output    | out_valid/out_ready | header fields, truncated
//
// each byte is taken in the idle phase, sent bit by bit through the step
// sequencer, then wrapped up. a byte marked last loads the result register
// and restarts the parse; if the previous result is still waiting, the
// wrap phase holds.
// synchronous active-low reset puts the parser at the profile element.
// in_ready is high whenever no byte is being parsed.

module av1_sequence_header_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_payload_byte,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_profile,
  output logic [4:0]  out_level_index,
  output logic        out_tier_high,
  output logic        out_delay_present,
  output logic [3:0]  out_delay_minus_one,
  output logic [16:0] out_max_width,
  output logic [16:0] out_max_height,
  output logic [1:0]  out_depth_code,
  output logic        out_mono,
  output logic [1:0]  out_subsampling_xy,
  output logic [1:0]  out_sample_position,
  output logic        out_truncated
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_BITS = 2'd1;
  localparam logic [1:0] PH_WRAP = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic [2:0] bitcnt_r, bitcnt_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;

  av1sh_pkg::step_t step_r, step_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [5:0]  left_r, left_nxt;
  logic [5:0]  zc_r, zc_nxt;
  logic [4:0]  opcnt_r, opcnt_nxt;
  logic [4:0]  opidx_r, opidx_nxt;
  logic [4:0]  dlen_r, dlen_nxt;
  logic        red_r, red_nxt, dmi_r, dmi_nxt, idd_r, idd_nxt, oh_r, oh_nxt;
  logic        hbd_r, hbd_nxt, twelve_r, twelve_nxt;
  logic [3:0]  fw_r, fw_nxt, fh_r, fh_nxt;
  logic [23:0] cdesc_r, cdesc_nxt;
  logic        done_r, done_nxt;
  logic [2:0]  prof_r, prof_nxt;
  logic [4:0]  lvl_r, lvl_nxt;
  logic        tier_r, tier_nxt, dpres_r, dpres_nxt;
  logic [3:0]  delay_r, delay_nxt;
  logic [16:0] width_r, width_nxt, height_r, height_nxt;
  logic        mono_r, mono_nxt;
  logic [1:0]  ss_r, ss_nxt, csp_r, csp_nxt;

  logic        oval_r, oval_nxt;
  logic        in_acc, out_load, clr;

  av1sh_pkg::step_ctl_t ctl_cur, ctl_go;
  av1sh_pkg::step_t     g_step, nop_step, adm_step, atier_step, aimv_step, atw_step;
  logic        g_en, fin, b, idx0;
  logic [31:0] v;
  logic [23:0] cd_new;

  assign in_ready  = (phase_r == PH_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = oval_r;
  assign out_load  = (phase_r == PH_WRAP) && last_r && (!oval_r || out_ready);
  assign clr       = out_load;

  // byte shifter and phase control
  always_comb begin
    phase_nxt  = phase_r;
    bitcnt_nxt = bitcnt_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    oval_nxt   = oval_r && !out_ready;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_acc) begin
          byte_nxt   = in_payload_byte;
          last_nxt   = in_is_last;
          bitcnt_nxt = 3'd0;
          phase_nxt  = PH_BITS;
        end
      end
      PH_BITS: begin
        byte_nxt   = {byte_r[6:0], 1'b0};
        bitcnt_nxt = bitcnt_r + 3'd1;
        if (bitcnt_r == 3'd7) phase_nxt = PH_WRAP;
      end
      PH_WRAP: begin
        if (!last_r) phase_nxt = PH_IDLE;
        else if (out_load) begin
          phase_nxt = PH_IDLE;
          oval_nxt  = 1'b1;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // helper successors shared by several steps
  assign idx0       = (opidx_r == 5'd0);
  assign nop_step   = (opidx_r >= opcnt_r) ? av1sh_pkg::S_FWB : av1sh_pkg::S_OP_IDC;
  assign adm_step   = idd_r ? av1sh_pkg::S_OP_IDD_P : nop_step;
  assign atier_step = dmi_r ? av1sh_pkg::S_OP_DM : adm_step;
  assign aimv_step  = oh_r ? av1sh_pkg::S_OH_BITS : av1sh_pkg::S_TAIL3;
  assign atw_step   = (prof_r == 3'd1) ? av1sh_pkg::S_CD : av1sh_pkg::S_MONO;

  assign b       = byte_r[7];
  assign v       = {acc_r[30:0], b};
  assign ctl_cur = av1sh_pkg::step_ctl(step_r);
  assign ctl_go  = av1sh_pkg::step_ctl(g_step);
  assign cd_new  = {cdesc_r[23:8], v[7:0]};

  // syntax sequencer: one bit per cycle while a byte is being shifted
  always_comb begin
    step_nxt = step_r;   acc_nxt = acc_r;     left_nxt = left_r;   zc_nxt = zc_r;
    opcnt_nxt = opcnt_r; opidx_nxt = opidx_r; dlen_nxt = dlen_r;
    red_nxt = red_r;     dmi_nxt = dmi_r;     idd_nxt = idd_r;     oh_nxt = oh_r;
    hbd_nxt = hbd_r;     twelve_nxt = twelve_r;
    fw_nxt = fw_r;       fh_nxt = fh_r;       cdesc_nxt = cdesc_r; done_nxt = done_r;
    prof_nxt = prof_r;   lvl_nxt = lvl_r;     tier_nxt = tier_r;   dpres_nxt = dpres_r;
    delay_nxt = delay_r; width_nxt = width_r; height_nxt = height_r;
    mono_nxt = mono_r;   ss_nxt = ss_r;       csp_nxt = csp_r;
    g_en   = 1'b0;
    g_step = ctl_cur.nxt;
    fin    = 1'b0;

    if ((phase_r == PH_BITS) && !done_r) begin
      if (step_r == av1sh_pkg::S_UVLC_ZERO) begin
        if (!b) begin
          if (zc_r < av1sh_pkg::UVLC_MAX) zc_nxt = zc_r + 6'd1;
        end else begin
          g_en   = 1'b1;
          g_step = ((zc_r == 6'd0) || (zc_r >= av1sh_pkg::UVLC_MAX)) ?
                   av1sh_pkg::S_DMI : av1sh_pkg::S_UVLC_VAL;
        end
      end else if (left_r > 6'd1) begin
        acc_nxt  = v;
        left_nxt = left_r - 6'd1;
      end else begin
        acc_nxt  = v;
        left_nxt = 6'd0;
        fin      = 1'b1;
      end
    end

    // element complete: store fields and pick the successor
    if (fin) begin
      g_en = 1'b1;
      case (step_r)
        av1sh_pkg::S_PROFILE: prof_nxt = v[2:0];
        av1sh_pkg::S_REDUCED: begin
          red_nxt = v[0];
          g_step  = v[0] ? av1sh_pkg::S_LEVEL_R : av1sh_pkg::S_TIMING;
        end
        av1sh_pkg::S_LEVEL_R: begin
          lvl_nxt = v[4:0]; tier_nxt = 1'b0; dpres_nxt = 1'b0;
        end
        av1sh_pkg::S_TIMING: begin
          if (v[0]) g_step = av1sh_pkg::S_NUM_UNITS;
          else dmi_nxt = 1'b0;
        end
        av1sh_pkg::S_EQUAL_PIC: begin
          if (v[0]) begin
            zc_nxt = 6'd0;
            g_step = av1sh_pkg::S_UVLC_ZERO;
          end
        end
        av1sh_pkg::S_DMI: begin
          dmi_nxt = v[0];
          g_step  = v[0] ? av1sh_pkg::S_BUF_LEN : av1sh_pkg::S_IDD;
        end
        av1sh_pkg::S_BUF_LEN: dlen_nxt = v[4:0];
        av1sh_pkg::S_IDD: begin
          idd_nxt = v[0]; dpres_nxt = v[0];
        end
        av1sh_pkg::S_OP_CNT: begin
          opcnt_nxt = v[4:0]; opidx_nxt = 5'd0;
        end
        av1sh_pkg::S_OP_LEVEL: begin
          if (idx0) begin
            lvl_nxt = v[4:0]; tier_nxt = 1'b0; delay_nxt = 4'd0;
          end
          g_step = (v[4:0] > 5'd7) ? av1sh_pkg::S_OP_TIER : atier_step;
        end
        av1sh_pkg::S_OP_TIER: begin
          if (idx0) tier_nxt = v[0];
          g_step = atier_step;
        end
        av1sh_pkg::S_OP_DM:   g_step = v[0] ? av1sh_pkg::S_OP_DEC : adm_step;
        av1sh_pkg::S_OP_LOW:  g_step = adm_step;
        av1sh_pkg::S_OP_IDD_P: g_step = v[0] ? av1sh_pkg::S_OP_IDD : nop_step;
        av1sh_pkg::S_OP_IDD: begin
          if (idx0) delay_nxt = v[3:0];
          g_step = nop_step;
        end
        av1sh_pkg::S_FWB: fw_nxt = v[3:0];
        av1sh_pkg::S_FHB: fh_nxt = v[3:0];
        av1sh_pkg::S_FW:  width_nxt = v[16:0] + 17'd1;
        av1sh_pkg::S_FH: begin
          height_nxt = v[16:0] + 17'd1;
          g_step = red_r ? av1sh_pkg::S_TOOLS3 : av1sh_pkg::S_FID;
        end
        av1sh_pkg::S_FID:    g_step = v[0] ? av1sh_pkg::S_DFID : av1sh_pkg::S_TOOLS3;
        av1sh_pkg::S_TOOLS3: g_step = red_r ? av1sh_pkg::S_TAIL3 : av1sh_pkg::S_TOOLS4;
        av1sh_pkg::S_OH: begin
          oh_nxt = v[0];
          g_step = v[0] ? av1sh_pkg::S_JNT : av1sh_pkg::S_CH_SCT;
        end
        av1sh_pkg::S_CH_SCT: g_step = v[0] ? av1sh_pkg::S_CH_IMV : av1sh_pkg::S_FO_SCT;
        av1sh_pkg::S_FO_SCT: g_step = v[0] ? av1sh_pkg::S_CH_IMV : aimv_step;
        av1sh_pkg::S_CH_IMV: g_step = v[0] ? aimv_step : av1sh_pkg::S_FO_IMV;
        av1sh_pkg::S_FO_IMV: g_step = aimv_step;
        av1sh_pkg::S_HBD: begin
          hbd_nxt = v[0]; twelve_nxt = 1'b0;
          if ((prof_r == 3'd2) && v[0]) g_step = av1sh_pkg::S_TWELVE;
          else begin
            g_step = atw_step;
            if (prof_r == 3'd1) mono_nxt = 1'b0;
          end
        end
        av1sh_pkg::S_TWELVE: begin
          twelve_nxt = v[0];
          g_step = atw_step;
          if (prof_r == 3'd1) mono_nxt = 1'b0;
        end
        av1sh_pkg::S_MONO: mono_nxt = v[0];
        av1sh_pkg::S_CD: begin
          if (!v[0]) begin
            cdesc_nxt = av1sh_pkg::CDESC_UNSPEC;
            g_step    = av1sh_pkg::S_RANGE;
            if (mono_r) ss_nxt = 2'd3;
          end
        end
        av1sh_pkg::S_CP: cdesc_nxt = {v[7:0], cdesc_r[15:0]};
        av1sh_pkg::S_TC: cdesc_nxt = {cdesc_r[23:16], v[7:0], cdesc_r[7:0]};
        av1sh_pkg::S_MC: begin
          cdesc_nxt = cd_new;
          if (mono_r) ss_nxt = 2'd3;
          else if (cd_new == av1sh_pkg::CDESC_SRGB) begin
            ss_nxt = 2'd0;
            g_step = av1sh_pkg::S_SEP_UV;
          end
        end
        av1sh_pkg::S_RANGE: begin
          if (mono_r) g_step = av1sh_pkg::S_FILM;
          else if (prof_r == 3'd0) begin
            ss_nxt = 2'd3; g_step = av1sh_pkg::S_CSP;
          end else if (prof_r == 3'd1) ss_nxt = 2'd0;
          else if ((prof_r == 3'd2) && hbd_r && twelve_r) g_step = av1sh_pkg::S_SSX;
          else ss_nxt = 2'd2;
        end
        av1sh_pkg::S_SSX: begin
          if (!v[0]) begin
            ss_nxt = 2'd0; g_step = av1sh_pkg::S_SEP_UV;
          end
        end
        av1sh_pkg::S_SSY: begin
          ss_nxt = {1'b1, v[0]};
          g_step = v[0] ? av1sh_pkg::S_CSP : av1sh_pkg::S_SEP_UV;
        end
        av1sh_pkg::S_CSP: csp_nxt = v[1:0];
        av1sh_pkg::S_FILM: begin
          done_nxt = 1'b1; g_en = 1'b0;
        end
        av1sh_pkg::S_STILL, av1sh_pkg::S_NUM_UNITS, av1sh_pkg::S_TIME_SCL,
        av1sh_pkg::S_UVLC_VAL, av1sh_pkg::S_DEC_TICK, av1sh_pkg::S_BRT_LEN,
        av1sh_pkg::S_FPT_LEN, av1sh_pkg::S_OP_IDC, av1sh_pkg::S_OP_DEC,
        av1sh_pkg::S_OP_ENC, av1sh_pkg::S_DFID, av1sh_pkg::S_AFID,
        av1sh_pkg::S_TOOLS4, av1sh_pkg::S_JNT, av1sh_pkg::S_OH_BITS,
        av1sh_pkg::S_TAIL3, av1sh_pkg::S_SEP_UV: ;
        default: begin
          done_nxt = 1'b1; g_en = 1'b0;
        end
      endcase
      // loop back to the next operating point
      if ((step_r >= av1sh_pkg::S_OP_LEVEL) && (step_r <= av1sh_pkg::S_OP_IDD) &&
          (g_step == av1sh_pkg::S_OP_IDC))
        opidx_nxt = opidx_r + 5'd1;
    end

    // enter the next element: clear shifter, load its length
    if (g_en) begin
      step_nxt = g_step;
      acc_nxt  = 32'd0;
      case (ctl_go.len_kind)
        av1sh_pkg::LEN_ZC:   left_nxt = zc_r;
        av1sh_pkg::LEN_DLEN: left_nxt = {1'b0, dlen_r} + 6'd1;
        av1sh_pkg::LEN_FW:   left_nxt = {2'b00, fw_r} + 6'd1;
        av1sh_pkg::LEN_FH:   left_nxt = {2'b00, fh_r} + 6'd1;
        default:             left_nxt = ctl_go.len_const;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      bitcnt_r <= 3'd0;
      oval_r   <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      bitcnt_r <= bitcnt_nxt;
      oval_r   <= oval_nxt;
      last_r   <= last_nxt;
    end
  end

  // parse state, cleared by reset and at the end of each header
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      step_r <= av1sh_pkg::S_PROFILE; acc_r <= 32'd0; left_r <= 6'd3; zc_r <= 6'd0;
      opcnt_r <= 5'd0; opidx_r <= 5'd0; dlen_r <= 5'd0;
      red_r <= 1'b0; dmi_r <= 1'b0; idd_r <= 1'b0; oh_r <= 1'b0;
      hbd_r <= 1'b0; twelve_r <= 1'b0; fw_r <= 4'd0; fh_r <= 4'd0;
      cdesc_r <= av1sh_pkg::CDESC_UNSPEC; done_r <= 1'b0;
      prof_r <= 3'd0; lvl_r <= 5'd0; tier_r <= 1'b0; dpres_r <= 1'b0;
      delay_r <= 4'd0; width_r <= 17'd0; height_r <= 17'd0;
      mono_r <= 1'b0; ss_r <= 2'd0; csp_r <= 2'd0;
    end else begin
      step_r <= step_nxt; acc_r <= acc_nxt; left_r <= left_nxt; zc_r <= zc_nxt;
      opcnt_r <= opcnt_nxt; opidx_r <= opidx_nxt; dlen_r <= dlen_nxt;
      red_r <= red_nxt; dmi_r <= dmi_nxt; idd_r <= idd_nxt; oh_r <= oh_nxt;
      hbd_r <= hbd_nxt; twelve_r <= twelve_nxt; fw_r <= fw_nxt; fh_r <= fh_nxt;
      cdesc_r <= cdesc_nxt; done_r <= done_nxt;
      prof_r <= prof_nxt; lvl_r <= lvl_nxt; tier_r <= tier_nxt; dpres_r <= dpres_nxt;
      delay_r <= delay_nxt; width_r <= width_nxt; height_r <= height_nxt;
      mono_r <= mono_nxt; ss_r <= ss_nxt; csp_r <= csp_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    if (out_load) begin
      out_truncated       <= !done_r;
      out_profile         <= done_r ? prof_r : 3'd0;
      out_level_index     <= done_r ? lvl_r : 5'd0;
      out_tier_high       <= done_r && tier_r;
      out_delay_present   <= done_r && dpres_r;
      out_delay_minus_one <= done_r ? delay_r : 4'd0;
      out_max_width       <= done_r ? width_r : 17'd0;
      out_max_height      <= done_r ? height_r : 17'd0;
      out_depth_code      <= (done_r && hbd_r) ? (twelve_r ? 2'd2 : 2'd1) : 2'd0;
      out_mono            <= done_r && mono_r;
      out_subsampling_xy  <= done_r ? ss_r : 2'd0;
      out_sample_position <= done_r ? csp_r : 2'd0;
    end
  end

endmodule

FILE: hw/rtl/av1sh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// av1sh_checker
// Port-level checks of the sequence header parser, bound to the top level.
// ----------------------------------------------------------------------------
module av1sh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_profile,
  input logic [16:0] out_max_width,
  input logic [16:0] out_max_height,
  input logic        out_truncated
);

  // a pending result beat stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a pending result beat keeps its width and truncated flag
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_max_width) && $stable(out_truncated))
    else $error("result payload changed while stalled");

  // in_ready is low in the cycle after a byte is taken
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  // truncated results carry zero fields
  a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> (out_profile == 3'd0) && (out_max_width == 17'd0))
    else $error("truncated result has nonzero fields");

  // a complete header has a frame size
  a_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_truncated |-> (out_max_width != 17'd0) && (out_max_height != 17'd0))
    else $error("complete header with zero frame size");

endmodule

bind av1_sequence_header_parser_core av1sh_checker u_av1sh_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_profile    (out_profile),
  .out_max_width  (out_max_width),
  .out_max_height (out_max_height),
  .out_truncated  (out_truncated)
);
